// File: rtl/sspt_pkg.sv
package sspt_pkg;

  localparam int OP_W       = 3;
  localparam int SAMPLE_W   = 10;
  localparam int POS_W      = 12;
  localparam int ANGLE_W    = 12;
  localparam int PERIOD_W   = 7;
  localparam int TICK_W     = 6;
  localparam int SEC_W      = 6;
  localparam int MIN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [POS_W-1:0] POS_MIN     = 12'd619;
  localparam logic [POS_W-1:0] POS_MAX     = 12'd2619;
  localparam logic [POS_W-1:0] SCAN_STRIDE = 12'd10;
  localparam logic [POS_W-1:0] SMALL_STEP  = 12'd10;
  localparam logic [POS_W-1:0] LARGE_STEP  = 12'd100;

  localparam logic [SEC_W-1:0] SECONDS_PER_MINUTE = 6'd60;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd15;

  localparam int ANGLE_CALC_W = 14;
  localparam logic signed [ANGLE_CALC_W-1:0] ANGLE_OFFSET = 14'sd900;

  localparam int RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT = 19;
  localparam int QUOT_W      = 9;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_STEP_UP  = 3'd1,
    OP_STEP_DN  = 3'd2,
    OP_TOGGLE   = 3'd3,
    OP_START    = 3'd4,
    OP_SAMPLE   = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_PERIOD  = 2'd0,
    REG_AUTO_ENABLE  = 2'd1,
    REG_ANGLE_SIGNED = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [POS_W-1:0]          servo_command;
    logic                      scan_busy;
    logic                      scan_done;
    logic [SAMPLE_W-1:0]       peak_sample;
    logic signed [ANGLE_W-1:0] angle_tenths;
  } out_word_t;

endpackage

// File: rtl/sspt_if.sv
interface sspt_in_if;
  logic                          valid;
  logic                          ready;
  logic [sspt_pkg::OP_W-1:0]     op;
  logic [sspt_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, op, adc_sample, input ready);
  modport sink (input valid, op, adc_sample, output ready);
endinterface

interface sspt_out_if;
  logic                                valid;
  logic                                ready;
  logic [sspt_pkg::POS_W-1:0]          servo_command;
  logic                                scan_busy;
  logic                                scan_done;
  logic [sspt_pkg::SAMPLE_W-1:0]       peak_sample;
  logic signed [sspt_pkg::ANGLE_W-1:0] angle_tenths;

  modport source (output valid, servo_command, scan_busy, scan_done, peak_sample,
                  angle_tenths, input ready);
  modport sink (input valid, servo_command, scan_busy, scan_done, peak_sample,
                angle_tenths, output ready);
endinterface

interface sspt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sspt_pkg::CFG_IDX_W-1:0]  index;
  logic [sspt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/sspt_angle.sv
module sspt_angle (
  input  logic [sspt_pkg::POS_W-1:0]          position,
  input  logic                                angle_signed,
  output logic signed [sspt_pkg::ANGLE_W-1:0] angle_tenths
);

  logic signed [sspt_pkg::POS_W:0]                diff;
  logic [sspt_pkg::POS_W-1:0]                     mag;
  logic [sspt_pkg::POS_W+sspt_pkg::RECIP_W-1:0]   prod;
  logic [sspt_pkg::QUOT_W-1:0]                    quot;
  logic signed [sspt_pkg::ANGLE_CALC_W-1:0]       scaled;
  logic signed [sspt_pkg::ANGLE_CALC_W-1:0]       with_sign;
  logic signed [sspt_pkg::ANGLE_CALC_W-1:0]       shifted;

  always_comb begin
    diff = $signed({1'b0, position}) - $signed({1'b0, sspt_pkg::POS_MIN});
    mag  = diff[sspt_pkg::POS_W] ? sspt_pkg::POS_W'(-diff) : diff[sspt_pkg::POS_W-1:0];
    prod = mag * sspt_pkg::RECIP_TEN;
    quot = sspt_pkg::QUOT_W'(prod >> sspt_pkg::RECIP_SHIFT);
    scaled = $signed({2'b00, quot, 3'b000}) + $signed({5'b00000, quot});
    with_sign = diff[sspt_pkg::POS_W] ? -scaled : scaled;
    shifted = angle_signed ? with_sign - sspt_pkg::ANGLE_OFFSET : with_sign;
    angle_tenths = shifted[sspt_pkg::ANGLE_W-1:0];
  end

endmodule

// File: rtl/sspt_core.sv
module sspt_core #(
  parameter int SCAN_STEPS       = 200,
  parameter int TICKS_PER_SECOND = 50
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [sspt_pkg::OP_W-1:0]     op,
  input  logic [sspt_pkg::SAMPLE_W-1:0] adc_sample,
  input  sspt_pkg::cfg_wr_t             cfg_wr,
  output sspt_pkg::out_word_t           result
);

  localparam int IDX_W = $clog2(SCAN_STEPS + 1);

  logic [sspt_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic                          auto_r, auto_nxt;
  logic                          angle_signed_r, angle_signed_nxt;
  logic [sspt_pkg::POS_W-1:0]    servo_r, servo_nxt;
  logic [sspt_pkg::POS_W-1:0]    best_pos_r, best_pos_nxt;
  logic [sspt_pkg::SAMPLE_W-1:0] best_sample_r, best_sample_nxt;
  logic                          scanning_r, scanning_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic                          step_large_r, step_large_nxt;
  logic                          counting_r, counting_nxt;
  logic [sspt_pkg::TICK_W-1:0]   tick_r, tick_nxt;
  logic [sspt_pkg::SEC_W-1:0]    sec_r, sec_nxt;
  logic [sspt_pkg::MIN_W-1:0]    min_r, min_nxt;

  logic                          done;
  logic                          start;
  logic [sspt_pkg::POS_W-1:0]    step;
  logic signed [sspt_pkg::ANGLE_W-1:0] angle;

  always_comb begin
    period_nxt       = period_r;
    auto_nxt         = auto_r;
    angle_signed_nxt = angle_signed_r;
    servo_nxt        = servo_r;
    best_pos_nxt     = best_pos_r;
    best_sample_nxt  = best_sample_r;
    scanning_nxt     = scanning_r;
    idx_nxt          = idx_r;
    step_large_nxt   = step_large_r;
    counting_nxt     = counting_r;
    tick_nxt         = tick_r;
    sec_nxt          = sec_r;
    min_nxt          = min_r;
    done             = 1'b0;
    start            = 1'b0;
    step = step_large_r ? sspt_pkg::LARGE_STEP : sspt_pkg::SMALL_STEP;

    if (fire) begin
      case (sspt_pkg::op_t'(op))
        sspt_pkg::OP_TICK: begin
          if (auto_r && counting_r) begin
            tick_nxt = tick_r + 1'b1;
            if (tick_nxt >= sspt_pkg::TICK_W'(TICKS_PER_SECOND)) begin
              sec_nxt  = sec_r + 1'b1;
              tick_nxt = '0;
            end
            if (sec_nxt >= sspt_pkg::SECONDS_PER_MINUTE) begin
              min_nxt = min_r + 1'b1;
              sec_nxt = '0;
            end
            if (min_nxt == period_r) begin
              min_nxt = '0;
              start   = 1'b1;
            end
          end
        end
        sspt_pkg::OP_STEP_UP: begin
          scanning_nxt = 1'b0;
          counting_nxt = 1'b1;
          servo_nxt = (servo_r <= sspt_pkg::POS_MAX - step) ? servo_r + step
                                                             : sspt_pkg::POS_MAX;
          best_pos_nxt = servo_nxt;
        end
        sspt_pkg::OP_STEP_DN: begin
          scanning_nxt = 1'b0;
          counting_nxt = 1'b1;
          servo_nxt = (servo_r >= sspt_pkg::POS_MIN + step) ? servo_r - step
                                                             : sspt_pkg::POS_MIN;
          best_pos_nxt = servo_nxt;
        end
        sspt_pkg::OP_TOGGLE: begin
          step_large_nxt = !step_large_r;
        end
        sspt_pkg::OP_START: begin
          start = 1'b1;
        end
        sspt_pkg::OP_SAMPLE: begin
          if (scanning_r) begin
            if (adc_sample > best_sample_r) begin
              best_sample_nxt = adc_sample;
              best_pos_nxt    = servo_r;
            end
            if (idx_r >= IDX_W'(SCAN_STEPS)) begin
              servo_nxt    = best_pos_nxt;
              scanning_nxt = 1'b0;
              counting_nxt = 1'b1;
              done         = 1'b1;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              servo_nxt = servo_r + sspt_pkg::SCAN_STRIDE;
            end
          end else begin
            best_sample_nxt = adc_sample;
          end
        end
        default: begin
        end
      endcase

      if (start) begin
        scanning_nxt    = 1'b1;
        idx_nxt         = '0;
        counting_nxt    = 1'b0;
        best_sample_nxt = '0;
        servo_nxt       = sspt_pkg::POS_MIN;
      end
    end

    if (cfg_wr.valid) begin
      case (sspt_pkg::reg_idx_t'(cfg_wr.index))
        sspt_pkg::REG_SCAN_PERIOD: begin
          period_nxt = cfg_wr.data[sspt_pkg::PERIOD_W-1:0];
        end
        sspt_pkg::REG_AUTO_ENABLE: begin
          auto_nxt = cfg_wr.data[0];
          tick_nxt = '0;
          sec_nxt  = '0;
          min_nxt  = '0;
          if (cfg_wr.data[0] && !scanning_r) begin
            counting_nxt = 1'b1;
          end
        end
        sspt_pkg::REG_ANGLE_SIGNED: begin
          angle_signed_nxt = cfg_wr.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  sspt_angle u_angle (
    .position     (best_pos_nxt),
    .angle_signed (angle_signed_r),
    .angle_tenths (angle)
  );

  always_comb begin
    result.servo_command = servo_nxt;
    result.scan_busy     = scanning_nxt;
    result.scan_done     = done;
    result.peak_sample   = best_sample_nxt;
    result.angle_tenths  = angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r       <= sspt_pkg::PERIOD_RESET;
      auto_r         <= 1'b1;
      angle_signed_r <= 1'b1;
      servo_r        <= '0;
      best_pos_r     <= '0;
      best_sample_r  <= '0;
      scanning_r     <= 1'b0;
      idx_r          <= '0;
      step_large_r   <= 1'b1;
      counting_r     <= 1'b1;
      tick_r         <= '0;
      sec_r          <= '0;
      min_r          <= '0;
    end else begin
      period_r       <= period_nxt;
      auto_r         <= auto_nxt;
      angle_signed_r <= angle_signed_nxt;
      servo_r        <= servo_nxt;
      best_pos_r     <= best_pos_nxt;
      best_sample_r  <= best_sample_nxt;
      scanning_r     <= scanning_nxt;
      idx_r          <= idx_nxt;
      step_large_r   <= step_large_nxt;
      counting_r     <= counting_nxt;
      tick_r         <= tick_nxt;
      sec_r          <= sec_nxt;
      min_r          <= min_nxt;
    end
  end

endmodule

// File: rtl/servo_sweep_peak_tracker.sv
// Servo sweep peak tracker. Takes one word per clock on in_ch while out_ch is
// not stalled and returns one result word per input word on out_ch, in order.
// Each word is held in the input register, and its result is then captured in
// the result register, which drives out_ch. The rate of one word per cycle, with
// out_ch not stalled, is set by the state update: each word reads the tracker state left
// by the previous one and writes it back in the same cycle. An input register and
// a result register decouple the two sides: while a result waits to be taken, one
// further word is still accepted, and only then does in_ch stall. Configuration
// writes on cfg_ch are always ready and apply at once; write them only while no
// word is in flight.
module servo_sweep_peak_tracker #(
  parameter int SCAN_STEPS       = 200,
  parameter int TICKS_PER_SECOND = 50
) (
  input logic        clk,
  input logic        rst_n,
  sspt_in_if.sink    in_ch,
  sspt_out_if.source out_ch,
  sspt_cfg_if.sink   cfg_ch
);

  logic                          s1_valid_r;
  logic [sspt_pkg::OP_W-1:0]     s1_op_r;
  logic [sspt_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic                          out_valid_r;
  sspt_pkg::out_word_t           out_word_r;
  sspt_pkg::out_word_t           result;
  sspt_pkg::cfg_wr_t             cfg_wr;
  logic                          adv;
  logic                          fire;

  assign adv         = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_wr.valid = cfg_ch.valid;
    cfg_wr.index = cfg_ch.index;
    cfg_wr.data  = cfg_ch.data;
  end

  sspt_core #(
    .SCAN_STEPS       (SCAN_STEPS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .op         (s1_op_r),
    .adc_sample (s1_sample_r),
    .cfg_wr     (cfg_wr),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r     <= in_ch.op;
      s1_sample_r <= in_ch.adc_sample;
    end
    if (fire) begin
      out_word_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.servo_command = out_word_r.servo_command;
  assign out_ch.scan_busy     = out_word_r.scan_busy;
  assign out_ch.scan_done     = out_word_r.scan_done;
  assign out_ch.peak_sample   = out_word_r.peak_sample;
  assign out_ch.angle_tenths  = out_word_r.angle_tenths;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int SCAN_STEPS       = 200;
  localparam int TICKS_PER_SECOND = 50;

  localparam logic [sspt_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [sspt_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;

  class tracker_mirror #(int STEPS = 200, int TPS = 50);
    logic [sspt_pkg::PERIOD_W-1:0] period;
    bit                            auto_en;
    bit                            angle_sgn;
    logic [sspt_pkg::POS_W-1:0]    drive;
    logic [sspt_pkg::POS_W-1:0]    best_pos;
    logic [sspt_pkg::SAMPLE_W-1:0] best_reading;
    bit                            scanning;
    bit                            large_stride;
    bit                            counting;
    logic [7:0]                    sweep_idx;
    logic [sspt_pkg::TICK_W-1:0]   ticks;
    logic [sspt_pkg::SEC_W-1:0]    secs;
    logic [sspt_pkg::MIN_W-1:0]    mins;
    sspt_pkg::out_word_t           report_q[$];
    int errors, checked, sweeps_done, auto_starts, aborts, clamps;

    function new();
      period = sspt_pkg::PERIOD_RESET;
      auto_en = 1;
      angle_sgn = 1;
      drive = '0;
      best_pos = '0;
      best_reading = '0;
      scanning = 0;
      large_stride = 1;
      counting = 1;
      sweep_idx = '0;
      ticks = '0;
      secs = '0;
      mins = '0;
    endfunction

    function void write_reg(sspt_pkg::reg_idx_t idx, logic [sspt_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sspt_pkg::REG_SCAN_PERIOD: period = val;
        sspt_pkg::REG_AUTO_ENABLE: begin
          auto_en = val[0];
          ticks = '0;
          secs = '0;
          mins = '0;
          if (auto_en && !scanning) counting = 1;
        end
        sspt_pkg::REG_ANGLE_SIGNED: angle_sgn = val[0];
        default: ;
      endcase
    endfunction

    function void start_sweep();
      scanning = 1;
      sweep_idx = '0;
      counting = 0;
      best_reading = '0;
      drive = sspt_pkg::POS_MIN;
    endfunction

    function logic signed [sspt_pkg::ANGLE_W-1:0] angle_of(logic [sspt_pkg::POS_W-1:0] pos);
      int offset;
      int a;
      offset = int'(pos) - int'(sspt_pkg::POS_MIN);
      a = (offset / 10) * 9;
      if (angle_sgn) a -= 900;
      return a[sspt_pkg::ANGLE_W-1:0];
    endfunction

    function void take_word(logic [sspt_pkg::OP_W-1:0] op,
                            logic [sspt_pkg::SAMPLE_W-1:0] reading);
      logic [sspt_pkg::POS_W-1:0] stride;
      bit                         done;
      sspt_pkg::out_word_t        w;
      stride = large_stride ? sspt_pkg::LARGE_STEP : sspt_pkg::SMALL_STEP;
      done = 0;
      case (op)
        sspt_pkg::OP_TICK: begin
          if (auto_en && counting) begin
            ticks = ticks + 1'b1;
            if (ticks >= TPS) begin
              secs = secs + 1'b1;
              ticks = '0;
            end
            if (secs >= sspt_pkg::SECONDS_PER_MINUTE) begin
              mins = mins + 1'b1;
              secs = '0;
            end
            if (mins == period) begin
              mins = '0;
              start_sweep();
              auto_starts++;
            end
          end
        end
        sspt_pkg::OP_STEP_UP: begin
          if (scanning) aborts++;
          scanning = 0;
          counting = 1;
          if (drive <= sspt_pkg::POS_MAX - stride) begin
            drive = drive + stride;
          end else begin
            drive = sspt_pkg::POS_MAX;
            clamps++;
          end
          best_pos = drive;
        end
        sspt_pkg::OP_STEP_DN: begin
          if (scanning) aborts++;
          scanning = 0;
          counting = 1;
          if (drive >= sspt_pkg::POS_MIN + stride) begin
            drive = drive - stride;
          end else begin
            drive = sspt_pkg::POS_MIN;
            clamps++;
          end
          best_pos = drive;
        end
        sspt_pkg::OP_TOGGLE: large_stride = !large_stride;
        sspt_pkg::OP_START: start_sweep();
        sspt_pkg::OP_SAMPLE: begin
          if (scanning) begin
            if (reading > best_reading) begin
              best_reading = reading;
              best_pos = drive;
            end
            if (sweep_idx >= STEPS) begin
              drive = best_pos;
              scanning = 0;
              counting = 1;
              done = 1;
              sweeps_done++;
            end else begin
              sweep_idx = sweep_idx + 1'b1;
              drive = drive + sspt_pkg::SCAN_STRIDE;
            end
          end else begin
            best_reading = reading;
          end
        end
        default: ;
      endcase
      w.servo_command = drive;
      w.scan_busy     = scanning;
      w.scan_done     = done;
      w.peak_sample   = best_reading;
      w.angle_tenths  = angle_of(best_pos);
      report_q.push_back(w);
    endfunction

    function void check_report(sspt_pkg::out_word_t got);
      sspt_pkg::out_word_t want;
      if (report_q.size() == 0) begin
        $error("result word arrived with no input word pending");
        errors++;
        return;
      end
      want = report_q.pop_front();
      checked++;
      if (got.servo_command !== want.servo_command) begin
        $error("servo_command: expected %0d, got %0d", want.servo_command, got.servo_command);
        errors++;
      end
      if (got.scan_busy !== want.scan_busy) begin
        $error("scan_busy: expected %0d, got %0d", want.scan_busy, got.scan_busy);
        errors++;
      end
      if (got.scan_done !== want.scan_done) begin
        $error("scan_done: expected %0d, got %0d", want.scan_done, got.scan_done);
        errors++;
      end
      if (got.peak_sample !== want.peak_sample) begin
        $error("peak_sample: expected %0d, got %0d", want.peak_sample, got.peak_sample);
        errors++;
      end
      if (got.angle_tenths !== want.angle_tenths) begin
        $error("angle_tenths: expected %0d, got %0d", want.angle_tenths, got.angle_tenths);
        errors++;
      end
    endfunction

    function int pending();
      return report_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sspt_in_if  in_bus();
  sspt_out_if out_bus();
  sspt_cfg_if cfg_bus();

  tracker_mirror #(SCAN_STEPS, TICKS_PER_SECOND) mirror;

  int burst_left = 0;
  int sent_count = 0;
  int sweep_no   = 0;

  servo_sweep_peak_tracker #(
    .SCAN_STEPS(SCAN_STEPS),
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic send_word(input logic [sspt_pkg::OP_W-1:0] op,
                           input logic [sspt_pkg::SAMPLE_W-1:0] reading);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      if ($urandom_range(0, 9) == 0)
        burst_left = $urandom_range(60, 200);
      else
        burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.adc_sample <= reading;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    mirror.take_word(op, reading);
    if (op <= sspt_pkg::OP_SAMPLE) sent_count++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input sspt_pkg::reg_idx_t idx,
                           input logic [sspt_pkg::CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    mirror.write_reg(idx, val);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [sspt_pkg::SAMPLE_W-1:0] any_reading();
    return sspt_pkg::SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [sspt_pkg::SAMPLE_W-1:0] pick_reading(int flavour);
    case (flavour)
      1: return '0;
      2: return sspt_pkg::SAMPLE_W'($urandom_range(0, 3));
      3: begin
        if ($urandom_range(0, 19) == 0) return sspt_pkg::SAMPLE_W'($urandom_range(512, 1023));
        return sspt_pkg::SAMPLE_W'($urandom_range(0, 63));
      end
      default: return any_reading();
    endcase
  endfunction

  task automatic run_random(input int target);
    int start_count;
    int r;
    int len;
    int flavour;
    logic [sspt_pkg::OP_W-1:0] op;
    start_count = sent_count;
    while (sent_count - start_count < target) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        flavour = sweep_no % 4;
        sweep_no++;
        send_word(sspt_pkg::OP_START, any_reading());
        while (mirror.scanning) begin
          r = $urandom_range(0, 799);
          if (r < 12) begin
            case ($urandom_range(0, 4))
              0: op = sspt_pkg::OP_TICK;
              1: op = sspt_pkg::OP_TOGGLE;
              2: op = OP_UNDEF_LO;
              3: op = OP_UNDEF_HI;
              default: op = sspt_pkg::OP_START;
            endcase
            send_word(op, any_reading());
          end else if (r == 12) begin
            op = $urandom_range(0, 1) ? sspt_pkg::OP_STEP_UP : sspt_pkg::OP_STEP_DN;
            send_word(op, any_reading());
          end else begin
            send_word(sspt_pkg::OP_SAMPLE, pick_reading(flavour));
          end
        end
      end else if (r < 45) begin
        if ($urandom_range(0, 1)) send_word(sspt_pkg::OP_TOGGLE, any_reading());
        op = $urandom_range(0, 1) ? sspt_pkg::OP_STEP_UP : sspt_pkg::OP_STEP_DN;
        len = $urandom_range(5, 25);
        repeat (len) send_word(op, any_reading());
      end else if (r < 55) begin
        len = $urandom_range(10, 80);
        repeat (len) send_word(sspt_pkg::OP_TICK, any_reading());
      end else begin
        len = $urandom_range(10, 40);
        repeat (len) send_word(sspt_pkg::OP_W'($urandom_range(0, 7)), any_reading());
      end
    end
  endtask

  initial begin
    int mode;
    int span;
    int held;
    out_bus.ready = 1'b0;
    mode = 0;
    span = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if ((held == 0 && mirror.checked >= 300) || (held == 1 && mirror.checked >= 800)) begin
        held++;
        out_bus.ready <= 1'b0;
        repeat (150) @(negedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 96);
      end
      span--;
      case (mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= 1'($urandom_range(0, 1));
        2: out_bus.ready <= (span % 3 != 0);
        default: out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    sspt_pkg::out_word_t got;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.servo_command = out_bus.servo_command;
      got.scan_busy     = out_bus.scan_busy;
      got.scan_done     = out_bus.scan_done;
      got.peak_sample   = out_bus.peak_sample;
      got.angle_tenths  = out_bus.angle_tenths;
      mirror.check_report(got);
    end
  end

  initial begin
    int k;
    mirror = new();
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = sspt_pkg::OP_TICK;
    in_bus.adc_sample = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = sspt_pkg::REG_SCAN_PERIOD;
    cfg_bus.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(OP_UNDEF_LO, 10'd1023);
    send_word(OP_UNDEF_HI, 10'd0);
    send_word(sspt_pkg::OP_TICK, 10'd0);
    send_word(sspt_pkg::OP_SAMPLE, 10'd1023);
    send_word(sspt_pkg::OP_SAMPLE, 10'd0);
    send_word(sspt_pkg::OP_STEP_UP, 10'd1023);
    send_word(sspt_pkg::OP_STEP_DN, 10'd0);
    send_word(sspt_pkg::OP_STEP_DN, 10'd0);
    send_word(sspt_pkg::OP_TOGGLE, 10'd0);
    send_word(sspt_pkg::OP_STEP_UP, 10'd0);
    send_word(sspt_pkg::OP_STEP_DN, 10'd0);
    send_word(sspt_pkg::OP_STEP_DN, 10'd0);
    send_word(sspt_pkg::OP_TOGGLE, 10'd1023);
    send_word(sspt_pkg::OP_START, 10'd0);
    send_word(sspt_pkg::OP_SAMPLE, 10'd5);
    send_word(sspt_pkg::OP_TICK, 10'd0);
    send_word(sspt_pkg::OP_START, 10'd0);
    send_word(sspt_pkg::OP_SAMPLE, 10'd7);
    send_word(sspt_pkg::OP_SAMPLE, 10'd1023);
    send_word(sspt_pkg::OP_STEP_UP, 10'd0);
    send_word(sspt_pkg::OP_SAMPLE, 10'd1023);

    settle();
    write_reg(sspt_pkg::REG_SCAN_PERIOD, 7'd1);
    write_reg(sspt_pkg::REG_AUTO_ENABLE, 7'd1);
    write_reg(sspt_pkg::REG_ANGLE_SIGNED, 7'd0);
    for (k = 0; k < 120; k++) begin
      if ($urandom_range(0, 49) == 0)
        send_word($urandom_range(0, 1) ? sspt_pkg::OP_SAMPLE : sspt_pkg::OP_TOGGLE,
                  any_reading());
      else
        send_word(sspt_pkg::OP_TICK, any_reading());
    end
    run_random(150);

    settle();
    write_reg(sspt_pkg::REG_AUTO_ENABLE, 7'd0);
    run_random(150);

    settle();
    write_reg(sspt_pkg::REG_SCAN_PERIOD, 7'd99);
    write_reg(sspt_pkg::REG_AUTO_ENABLE, 7'd1);
    write_reg(sspt_pkg::REG_ANGLE_SIGNED, 7'd1);
    run_random(150);

    send_word(sspt_pkg::OP_START, 10'd0);
    settle();
    write_reg(sspt_pkg::REG_AUTO_ENABLE, 7'd1);
    write_reg(sspt_pkg::REG_SCAN_PERIOD, sspt_pkg::CFG_DATA_W'($urandom_range(1, 99)));
    write_reg(sspt_pkg::REG_ANGLE_SIGNED, sspt_pkg::CFG_DATA_W'($urandom_range(0, 1)));
    run_random(150);

    settle();
    repeat (10) @(negedge clk);

    $display("Checked %0d result words: %0d sweeps completed, %0d aborted, %0d timer-started.",
             mirror.checked, mirror.sweeps_done, mirror.aborts, mirror.auto_starts);
    $display("Hit %0d position clamps; ran ticks with the timer on and off, both angle modes.",
             mirror.clamps);
    if (mirror.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
